>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the tagged handle stack.
// No dependencies; the macros reduce to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/its_pkg.sv
// Shared types and constants for the tagged handle stack.
// No dependencies; used by its_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

    localparam int HANDLE_W  = 16;
    localparam int ID_W      = 16;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int BUSY_W    = 16;
    localparam int DEPTH_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BUSY_BEGIN = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BUSY_END   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_BUSY_SMASH = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Per-cell update command, broadcast along the row
    typedef enum logic [2:0] {
        CELL_HOLD,      // keep contents
        CELL_WRITE,     // load handle and ID at the write position
        CELL_SET_AT,    // load handle only at the write position
        CELL_SET_HIT,   // load handle in the lowest matching cell
        CELL_REMOVE     // matching cell and all above take their upper neighbor
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

>>> rtl/id_tagged_stack_with_busy_overlay.sv
// Tagged handle stack with remove-by-ID and busy overlay. When a request is
// taken, every cell compares its stored ID with cursor_id into a match flag;
// in S_EXEC, unless the output is stalled, the first match is resolved along
// the row of cells, the stack is updated and the result lands in the output
// register. The next request can be taken while that result waits. IDs start
// at 1 and skip 0 on wrap; slot contents need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module id_tagged_stack_with_busy_overlay #(
    parameter int DEPTH = its_pkg::DEPTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [its_pkg::HANDLE_W-1:0]     cfg_wdata,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [its_pkg::REQ_W-1:0]        req_type,
    input  wire  [its_pkg::HANDLE_W-1:0]     cursor,
    input  wire  [its_pkg::ID_W-1:0]         cursor_id,
    input  wire                              activate_now,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [its_pkg::STATUS_W-1:0]     status,
    output logic [its_pkg::ID_W-1:0]         new_id,
    output logic [its_pkg::HANDLE_W-1:0]     old_cursor,
    output logic                             old_valid,
    output logic                             show_update,
    output logic [its_pkg::HANDLE_W-1:0]     shown_cursor,
    output logic                             busy_active,
    output logic [$clog2(DEPTH+1)-1:0]       depth
);
    import its_pkg::*;

    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control and request registers
    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_reg;
    logic [HANDLE_W-1:0] cur_reg;
    logic [ID_W-1:0]     cid_reg;
    logic                act_reg;
    logic [LVL_W-1:0]    fill_reg, fill_next;
    logic [BUSY_W-1:0]   busy_reg, busy_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [HANDLE_W-1:0] busy_cursor_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     new_id_reg, new_id_next;
    logic [HANDLE_W-1:0] old_cursor_reg, old_cursor_next;
    logic                old_valid_reg, old_valid_next;
    logic                upd_reg, upd_next;
    logic [HANDLE_W-1:0] shown_reg, shown_next;

    logic                accept;
    logic                exec_fire;

    // Cell row wiring
    logic [HANDLE_W-1:0] cell_handle [DEPTH];
    logic [ID_W-1:0]     cell_id     [DEPTH];
    logic                hit_chain   [DEPTH+1];
    logic [HANDLE_W-1:0] sel_chain   [DEPTH+1];
    cell_cmd_t           cmd;
    cell_cmd_t           cmd_gated;
    logic [IDX_W-1:0]    wpos;

    // Stack view
    logic [LVL_W-1:0]    fill_m1, fill_m2;
    logic [HANDLE_W-1:0] top1, top2, top_new;
    logic                hit_below_top;
    logic                empty, full, found;
    logic [ID_W-1:0]     id_inc;

    assign hit_chain[0] = 1'b0;
    assign sel_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [HANDLE_W-1:0] up_handle;
            logic [ID_W-1:0]     up_id;
            if (g < DEPTH - 1)
            begin : g_mid
                assign up_handle = cell_handle[g+1];
                assign up_id     = cell_id[g+1];
            end
            else
            begin : g_top
                assign up_handle = cell_handle[g];
                assign up_id     = cell_id[g];
            end
            its_cell #(
                .IDX   (g),
                .IDX_W (IDX_W),
                .LVL_W (LVL_W)
            ) u_cell (
                .clk          (clk),
                .load_match   (accept),
                .cmp_id       (cursor_id),
                .fill         (fill_reg),
                .cmd          (cmd_gated),
                .wpos         (wpos),
                .hit_in       (hit_chain[g]),
                .sel_in       (sel_chain[g]),
                .above_handle (up_handle),
                .above_id     (up_id),
                .hit_out      (hit_chain[g+1]),
                .sel_out      (sel_chain[g+1]),
                .handle       (cell_handle[g]),
                .id           (cell_id[g])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EXEC:
            begin
                exec_fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Top-of-stack view: entries at fill-1 and fill-2, match below the top
    always_comb
    begin
        fill_m1       = fill_reg - LVL_W'(1);
        fill_m2       = fill_reg - LVL_W'(2);
        top1          = '0;
        top2          = '0;
        hit_below_top = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (fill_m1[IDX_W-1:0] == IDX_W'(i))
            begin
                top1 = cell_handle[i];
            end
            if (fill_m2[IDX_W-1:0] == IDX_W'(i))
            begin
                top2 = cell_handle[i];
            end
        end
        for (int k = 0; k <= DEPTH; k++)
        begin
            if (fill_m1 == LVL_W'(k))
            begin
                hit_below_top = hit_chain[k];
            end
        end
        empty  = (fill_reg == '0);
        full   = (fill_reg == LVL_W'(DEPTH));
        found  = hit_chain[DEPTH];
        id_inc = next_id_reg + ID_W'(1);
        if (id_inc == '0)
        begin
            id_inc = ID_W'(1);
        end
    end

    // Request decode and result
    always_comb
    begin
        status_next     = ST_OK;
        new_id_next     = '0;
        old_cursor_next = '0;
        old_valid_next  = 1'b0;
        upd_next        = 1'b0;
        fill_next       = fill_reg;
        busy_next       = busy_reg;
        next_id_next    = next_id_reg;
        top_new         = top1;
        cmd.op          = CELL_HOLD;
        cmd.handle      = cur_reg;
        cmd.id          = next_id_reg;
        wpos            = fill_reg[IDX_W-1:0];
        case (req_reg)
            REQ_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    new_id_next  = next_id_reg;
                    next_id_next = id_inc;
                    cmd.op       = CELL_WRITE;
                    fill_next    = fill_reg + LVL_W'(1);
                    upd_next     = act_reg;
                    top_new      = cur_reg;
                end
            end
            REQ_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (cid_reg == '0)
                begin
                    fill_next       = fill_m1;
                    old_cursor_next = top1;
                    old_valid_next  = 1'b1;
                    top_new         = top2;
                end
                else if (found)
                begin
                    old_cursor_next = sel_chain[DEPTH];
                    old_valid_next  = 1'b1;
                    cmd.op          = CELL_REMOVE;
                    fill_next       = fill_m1;
                    upd_next        = (fill_m1 != '0);
                    top_new         = hit_below_top ? top1 : top2;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_SET:
            begin
                if (cid_reg == '0)
                begin
                    upd_next = 1'b1;
                    top_new  = cur_reg;
                    if (!empty)
                    begin
                        old_cursor_next = top1;
                        old_valid_next  = 1'b1;
                        cmd.op          = CELL_SET_AT;
                        wpos            = fill_m1[IDX_W-1:0];
                    end
                    else
                    begin
                        new_id_next  = next_id_reg;
                        next_id_next = id_inc;
                        cmd.op       = CELL_WRITE;
                        wpos         = '0;
                        fill_next    = LVL_W'(1);
                    end
                end
                else if (found)
                begin
                    old_cursor_next = sel_chain[DEPTH];
                    old_valid_next  = 1'b1;
                    if (sel_chain[DEPTH] != cur_reg)
                    begin
                        cmd.op   = CELL_SET_HIT;
                        upd_next = 1'b1;
                        top_new  = hit_below_top ? top1 : cur_reg;
                    end
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_BUSY_BEGIN:
            begin
                if (busy_reg != '1)
                begin
                    busy_next = busy_reg + BUSY_W'(1);
                end
                upd_next = !empty;
            end
            REQ_BUSY_END:
            begin
                if (busy_reg != '0)
                begin
                    busy_next = busy_reg - BUSY_W'(1);
                end
                upd_next = !empty;
            end
            REQ_BUSY_SMASH:
            begin
                if (busy_reg != '0)
                begin
                    busy_next = '0;
                    upd_next  = !empty;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        // Shown handle after the update
        if (busy_next != '0)
        begin
            shown_next = busy_cursor_reg;
        end
        else if (fill_next != '0)
        begin
            shown_next = top_new;
        end
        else
        begin
            shown_next = '0;
        end
    end

    // Cells change only when the result is committed
    always_comb
    begin
        cmd_gated = cmd;
        if (!exec_fire)
        begin
            cmd_gated.op = CELL_HOLD;
        end
    end

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            busy_reg        <= '0;
            next_id_reg     <= ID_W'(1);
            busy_cursor_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                busy_cursor_reg <= cfg_wdata;
            end
            if (exec_fire)
            begin
                fill_reg    <= fill_next;
                busy_reg    <= busy_next;
                next_id_reg <= next_id_next;
            end
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            cur_reg <= cursor;
            cid_reg <= cursor_id;
            act_reg <= activate_now;
        end
        if (exec_fire)
        begin
            status_reg     <= status_next;
            new_id_reg     <= new_id_next;
            old_cursor_reg <= old_cursor_next;
            old_valid_reg  <= old_valid_next;
            upd_reg        <= upd_next;
            shown_reg      <= shown_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign new_id       = new_id_reg;
    assign old_cursor   = old_cursor_reg;
    assign old_valid    = old_valid_reg;
    assign show_update  = upd_reg;
    assign shown_cursor = shown_reg;
    assign busy_active  = (busy_reg != '0);
    assign depth        = fill_reg;

    // Checks
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= LVL_W'(DEPTH))
    `ASSERT_ALWAYS(a_id_nonzero, clk, rst_n, next_id_reg != '0)
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `ASSERT_IMPLIES(a_overflow_clean, clk, rst_n, out_valid_reg && (status_reg == ST_OVERFLOW), (new_id_reg == '0) && !upd_reg && (fill_reg == LVL_W'(DEPTH)))

endmodule

`default_nettype wire

>>> rtl/its_cell.sv
// One stack slot: handle and ID registers, ID match flag and first-match chain.
// Depends on its_pkg.
`timescale 1ns / 1ps
`default_nettype none

module its_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int LVL_W = 5
) (
    input  wire                          clk,
    input  wire                          load_match,
    input  wire  [its_pkg::ID_W-1:0]     cmp_id,
    input  wire  [LVL_W-1:0]             fill,
    input  wire  its_pkg::cell_cmd_t     cmd,
    input  wire  [IDX_W-1:0]             wpos,
    input  wire                          hit_in,
    input  wire  [its_pkg::HANDLE_W-1:0] sel_in,
    input  wire  [its_pkg::HANDLE_W-1:0] above_handle,
    input  wire  [its_pkg::ID_W-1:0]     above_id,
    output logic                         hit_out,
    output logic [its_pkg::HANDLE_W-1:0] sel_out,
    output logic [its_pkg::HANDLE_W-1:0] handle,
    output logic [its_pkg::ID_W-1:0]     id
);
    import its_pkg::*;

    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [ID_W-1:0]     id_reg;
    logic [ID_W-1:0]     id_next;
    logic                match_reg;
    logic                match_next;
    logic                first;
    logic                at_wpos;

    // Match flag, captured when a request is taken
    always_comb
    begin
        match_next = match_reg;
        if (load_match)
        begin
            match_next = (id_reg == cmp_id) && (LVL_W'(IDX) < fill);
        end
    end

    // First-match chain
    always_comb
    begin
        first   = match_reg && !hit_in;
        hit_out = hit_in || match_reg;
        sel_out = first ? handle_reg : sel_in;
        at_wpos = (wpos == IDX_W'(IDX));
    end

    // Contents update
    always_comb
    begin
        handle_next = handle_reg;
        id_next     = id_reg;
        case (cmd.op)
            CELL_WRITE:
            begin
                if (at_wpos)
                begin
                    handle_next = cmd.handle;
                    id_next     = cmd.id;
                end
            end
            CELL_SET_AT:
            begin
                if (at_wpos)
                begin
                    handle_next = cmd.handle;
                end
            end
            CELL_SET_HIT:
            begin
                if (first)
                begin
                    handle_next = cmd.handle;
                end
            end
            CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    handle_next = above_handle;
                    id_next     = above_id;
                end
            end
            default:
            begin
                handle_next = handle_reg;
                id_next     = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        id_reg     <= id_next;
        match_reg  <= match_next;
    end

    assign handle = handle_reg;
    assign id     = id_reg;

endmodule

`default_nettype wire
